FILE: rtl/core/rbff_pkg.sv
// Shared constants, codes and control types of the ring buffer FIR filter.
package rbff_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int COEF_IDX_W    = 6;
   localparam int TAP_COUNT_W   = 7;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 7;
   localparam int FRAC_W        = 15;
   localparam int PROD_W        = 2 * SAMPLE_W;
   localparam int DEFAULT_TAPS  = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT     = 1'b1;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_COEF   = 1'b1;

   localparam logic                   FILTER_ENABLE_RESET = 1'b1;
   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET     = 7'd64;

   localparam int ROUND_BIAS = 16384;
   localparam int SAT_MAX    = 32767;

   typedef struct packed {
      logic load;
      logic rotate;
      logic shift_coef;
      logic sel_right;
   } cell_ctrl_type;

   typedef struct packed {
      logic                       sample_we;
      logic                       right;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       coef_we;
      logic [COEF_IDX_W-1:0]      coef_idx;
      logic signed [SAMPLE_W-1:0] coef_val;
   } cell_wr_type;

   typedef struct packed {
      logic clear;
      logic mac_en;
      logic last;
   } mac_ctrl_type;

endpackage

FILE: rtl/core/rbff_ifs.sv
// Handshake channel interfaces: sample/coefficient requests, results, register writes.
interface rbff_req_if import rbff_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic                       channel;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic [COEF_IDX_W-1:0]      coef_index;
   logic signed [SAMPLE_W-1:0] coef_value;

   modport source (output valid, action, channel, sample_in, coef_index, coef_value,
                   input ready);
   modport sink (input valid, action, channel, sample_in, coef_index, coef_value,
                 output ready);
endinterface

interface rbff_rsp_if import rbff_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink (input valid, sample_out, output ready);
endinterface

interface rbff_csr_if import rbff_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ring_buffer_fir_filter_top.sv
// Top level: stereo FIR filter over a chain of tap cells with one shared MAC.
//
//   channel  | dir | payload                                       | transfer on
//   req_if   | in  | action, channel, sample_in, coef_index, value | valid && ready
//   rsp_if   | out | sample_out                                    | valid && ready
//   csr_if   | in  | index, data (filter_enable, tap_count)        | valid (ready tied 1)
//
// For a filtered sample the line copy rotates through the cell chain into cell 0, which
// feeds the single multiplier: first by p places, p being the new write position, then
// over the len taps of the effective tap count during the MAC. A bypassed sample skips
// the MAC. Reset clears the stored samples and coefficients of all cells, not work taps.
// A result waits in the output register while the next request is taken.
module ring_buffer_fir_filter_top import rbff_pkg::*; #(
   parameter int TAPS = DEFAULT_TAPS
) (
   input logic       clock,
   input logic       reset,
   rbff_req_if.sink  req_if,
   rbff_rsp_if.source rsp_if,
   rbff_csr_if.sink  csr_if
);

   localparam int POS_W = $clog2(TAPS);
   localparam int LEN_W = $clog2(TAPS + 1);
   localparam int CMP_W = (LEN_W > TAP_COUNT_W) ? LEN_W : TAP_COUNT_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_RUN  = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic                       enable_ff;
   logic [TAP_COUNT_W-1:0]     tap_count_ff;
   logic [POS_W-1:0]           left_pos_ff, left_pos_in;
   logic [POS_W-1:0]           right_pos_ff, right_pos_in;
   logic [POS_W-1:0]           skip_ff, skip_in;
   logic [LEN_W-1:0]           taps_left_ff, taps_left_in;
   logic                       sel_right_ff, sel_right_in;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic                       req_xfer;
   logic [CMP_W-1:0]           tc_ext;
   logic [LEN_W-1:0]           len;
   logic [POS_W-1:0]           pos_raw;
   logic [POS_W-1:0]           p_cur;
   logic [LEN_W-1:0]           p_inc;
   logic [POS_W-1:0]           p_next;
   logic                       mac_done;
   logic signed [SAMPLE_W-1:0] mac_result;

   cell_ctrl_type              cell_ctrl;
   cell_wr_type                cell_wr;
   mac_ctrl_type               mac_ctrl;

   logic signed [SAMPLE_W-1:0] tap_s [TAPS];
   logic signed [SAMPLE_W-1:0] tap_c [TAPS];

   assign req_xfer      = req_if.valid && req_if.ready;
   assign req_if.ready  = state_ff == ST_IDLE;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_data_ff;

   // effective length and write position
   always_comb begin
      tc_ext = CMP_W'(tap_count_ff);
      priority if (tap_count_ff == '0) begin
         len = LEN_W'(1);
      end else if (tc_ext > CMP_W'(TAPS)) begin
         len = LEN_W'(TAPS);
      end else begin
         len = LEN_W'(tc_ext);
      end
      pos_raw = req_if.channel ? right_pos_ff : left_pos_ff;
      p_cur   = (LEN_W'(pos_raw) >= len) ? '0 : pos_raw;
      p_inc   = LEN_W'(p_cur) + LEN_W'(1);
      p_next  = (p_inc >= len) ? '0 : POS_W'(p_inc);
   end

   always_comb begin
      cell_wr.sample_we = req_xfer && (req_if.action == ACTION_SAMPLE);
      cell_wr.right     = req_if.channel;
      cell_wr.sample    = req_if.sample_in;
      cell_wr.coef_we   = req_xfer && (req_if.action == ACTION_COEF);
      cell_wr.coef_idx  = req_if.coef_index;
      cell_wr.coef_val  = req_if.coef_value;
   end

   always_comb begin
      state_in      = state_ff;
      left_pos_in   = left_pos_ff;
      right_pos_in  = right_pos_ff;
      skip_in       = skip_ff;
      taps_left_in  = taps_left_ff;
      sel_right_in  = sel_right_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;
      cell_ctrl     = '0;
      cell_ctrl.sel_right = sel_right_ff;
      mac_ctrl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_if.action == ACTION_SAMPLE)) begin
               if (req_if.channel) begin
                  right_pos_in = p_next;
               end else begin
                  left_pos_in = p_next;
               end
               if (enable_ff) begin
                  skip_in      = p_next;
                  taps_left_in = len;
                  sel_right_in = req_if.channel;
                  state_in     = ST_LOAD;
               end else begin
                  res_in   = req_if.sample_in;
                  state_in = ST_FIN;
               end
            end
         end
         ST_LOAD: begin
            cell_ctrl.load = 1'b1;
            mac_ctrl.clear = 1'b1;
            state_in       = ST_RUN;
         end
         ST_RUN: begin
            cell_ctrl.rotate = 1'b1;
            if (skip_ff != '0) begin
               skip_in = skip_ff - POS_W'(1);
            end else begin
               cell_ctrl.shift_coef = 1'b1;
               mac_ctrl.mac_en      = 1'b1;
               mac_ctrl.last        = taps_left_ff == LEN_W'(1);
               taps_left_in         = taps_left_ff - LEN_W'(1);
               if (mac_ctrl.last) begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               res_in   = mac_result;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         left_pos_ff  <= '0;
         right_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_pos_ff  <= left_pos_in;
         right_pos_ff <= right_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skip_ff      <= skip_in;
      taps_left_ff <= taps_left_in;
      sel_right_ff <= sel_right_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= FILTER_ENABLE_RESET;
         tap_count_ff <= TAP_COUNT_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            CSR_FILTER_ENABLE: enable_ff    <= csr_if.data[0];
            CSR_TAP_COUNT:     tap_count_ff <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      logic signed [SAMPLE_W-1:0] nxt_s;
      logic signed [SAMPLE_W-1:0] nxt_c;
      if (i + 1 < TAPS) begin : g_mid
         assign nxt_s = tap_s[i+1];
         assign nxt_c = tap_c[i+1];
      end else begin : g_end
         assign nxt_s = '0;
         assign nxt_c = '0;
      end
      rbff_cell #(
         .TAPS (TAPS),
         .IDX  (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .wr          (cell_wr),
         .wr_pos      (p_cur),
         .len         (len),
         .next_sample (nxt_s),
         .next_coef   (nxt_c),
         .head_sample (tap_s[0]),
         .tap_sample  (tap_s[i]),
         .tap_coef    (tap_c[i])
      );
   end

   rbff_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (tap_s[0]),
      .coef   (tap_c[0]),
      .done   (mac_done),
      .result (mac_result)
   );

endmodule

FILE: rtl/core/rbff_cell.sv
// One tap cell: stored left/right samples and coefficient, plus rotating work taps.
module rbff_cell import rbff_pkg::*; #(
   parameter int TAPS = DEFAULT_TAPS,
   parameter int IDX  = 0,
   localparam int POS_W = $clog2(TAPS),
   localparam int LEN_W = $clog2(TAPS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cell_ctrl_type              ctrl,
   input  cell_wr_type                wr,
   input  logic [POS_W-1:0]           wr_pos,
   input  logic [LEN_W-1:0]           len,
   input  logic signed [SAMPLE_W-1:0] next_sample,
   input  logic signed [SAMPLE_W-1:0] next_coef,
   input  logic signed [SAMPLE_W-1:0] head_sample,
   output logic signed [SAMPLE_W-1:0] tap_sample,
   output logic signed [SAMPLE_W-1:0] tap_coef
);

   localparam bit CAN_COEF = IDX < (1 << COEF_IDX_W);

   logic signed [SAMPLE_W-1:0] left_ff, left_in;
   logic signed [SAMPLE_W-1:0] right_ff, right_in;
   logic signed [SAMPLE_W-1:0] coef_ff, coef_in;
   logic signed [SAMPLE_W-1:0] tap_s_ff, tap_s_in;
   logic signed [SAMPLE_W-1:0] tap_c_ff, tap_c_in;
   logic                       pos_hit;
   logic                       coef_hit;
   logic                       is_last;

   assign pos_hit  = wr.sample_we && (wr_pos == POS_W'(IDX));
   assign coef_hit = CAN_COEF && wr.coef_we && (wr.coef_idx == COEF_IDX_W'(IDX));
   assign is_last  = len == LEN_W'(IDX + 1);

   always_comb begin
      left_in  = (pos_hit && !wr.right) ? wr.sample : left_ff;
      right_in = (pos_hit && wr.right) ? wr.sample : right_ff;
      coef_in  = coef_hit ? wr.coef_val : coef_ff;
   end

   always_comb begin
      priority if (ctrl.load) begin
         tap_s_in = ctrl.sel_right ? right_ff : left_ff;
      end else if (ctrl.rotate) begin
         tap_s_in = is_last ? head_sample : next_sample;
      end else begin
         tap_s_in = tap_s_ff;
      end
      priority if (ctrl.load) begin
         tap_c_in = coef_ff;
      end else if (ctrl.shift_coef) begin
         tap_c_in = next_coef;
      end else begin
         tap_c_in = tap_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= '0;
         coef_ff  <= '0;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
         coef_ff  <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_s_ff <= tap_s_in;
      tap_c_ff <= tap_c_in;
   end

   assign tap_sample = tap_s_ff;
   assign tap_coef   = tap_c_ff;

endmodule

FILE: rtl/core/rbff_mac.sv
// Shared multiply-accumulate with rounding to Q1.15 and symmetric saturation.
module rbff_mac import rbff_pkg::*; #(
   parameter int TAPS = DEFAULT_TAPS,
   localparam int ACC_W = PROD_W + $clog2(TAPS),
   localparam int RND_W = ACC_W + 1,
   localparam int Q_W   = RND_W - FRAC_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctrl_type               ctrl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic signed [SAMPLE_W-1:0] coef,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] result
);

   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(SAT_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX;

   logic signed [PROD_W-1:0]   prod_ff;
   logic                       pv_ff;
   logic                       plast_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       acc_done_ff;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic                       res_done_ff;
   logic signed [RND_W-1:0]    rnd;
   logic signed [Q_W-1:0]      q;

   always_comb begin
      priority if (ctrl.clear) begin
         acc_in = '0;
      end else if (pv_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_comb begin
      rnd = RND_W'(acc_ff) + RND_W'(ROUND_BIAS);
      q   = Q_W'(rnd >>> FRAC_W);
      priority if (q > Q_MAX) begin
         res_in = SAMPLE_W'(Q_MAX);
      end else if (q < Q_MIN) begin
         res_in = SAMPLE_W'(Q_MIN);
      end else begin
         res_in = SAMPLE_W'(q);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= sample * coef;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff       <= 1'b0;
         plast_ff    <= 1'b0;
         acc_done_ff <= 1'b0;
         res_done_ff <= 1'b0;
      end else begin
         pv_ff       <= ctrl.mac_en;
         plast_ff    <= ctrl.mac_en && ctrl.last;
         acc_done_ff <= pv_ff && plast_ff;
         res_done_ff <= acc_done_ff;
      end
   end

   assign done   = res_done_ff;
   assign result = res_ff;

endmodule
